[rtl/assert_macros.svh]
// Assertion macros shared by the frame store draw block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[rtl/mfpl_pkg.sv]
// Shared types and constants of the monochrome frame store draw block.
package mfpl_pkg;

  localparam int unsigned SCREEN_COLUMNS_DEF = 128;
  localparam int unsigned SCREEN_PAGES_DEF   = 8;

  localparam int unsigned COORD_W   = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COL_IN_W  = 7;
  localparam int unsigned PAGE_IN_W = 3;
  localparam int unsigned KIND_W    = 2;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 1;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_FIX,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_BYTE_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic pt_init;
    logic line_init;
    logic div_step;
    logic div_fix;
    logic pix_rd;
    logic pix_wr;
    logic byte_rd;
    logic clr_start;
    logic clr_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_last;
    logic  walk_last;
    logic  sweep_last;
  } sts_t;

endpackage

[rtl/mfpl_dp.sv]
// Datapath: command registers, slope divider, pixel walker and frame memory.
module mfpl_dp #(
  parameter int unsigned SCREEN_COLUMNS = mfpl_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_PAGES   = mfpl_pkg::SCREEN_PAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfpl_pkg::cmd_t                      cmd_i,
  output mfpl_pkg::sts_t                      sts_o,
  input  mfpl_pkg::kind_e                     kind_i,
  input  logic [mfpl_pkg::COORD_W-1:0]        start_x_i,
  input  logic [mfpl_pkg::COORD_W-1:0]        start_y_i,
  input  logic [mfpl_pkg::COORD_W-1:0]        end_x_i,
  input  logic [mfpl_pkg::COORD_W-1:0]        end_y_i,
  input  logic                                light_i,
  input  logic [mfpl_pkg::COL_IN_W-1:0]       read_column_i,
  input  logic [mfpl_pkg::PAGE_IN_W-1:0]      read_page_i,
  output logic [mfpl_pkg::BYTE_W-1:0]         read_data_o,
  output logic                                out_of_range_o
);
  import mfpl_pkg::*;

  localparam int unsigned DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ROWS   = SCREEN_PAGES * 8;

  // Captured command beat.
  kind_e                kind_q;
  logic [COORD_W-1:0]   sx_q, sy_q, ex_q, ey_q;
  logic                 light_q;
  logic [COL_IN_W-1:0]  rc_q;
  logic [PAGE_IN_W-1:0] rp_q;

  // Pixel walker.
  logic [COORD_W-1:0]   wx_q, wy_q, hi_q;
  logic                 vert_q, on_q;
  logic [COORD_W-1:0]   dxn_q, rs_q, acc_q;
  logic                 neg_q;
  logic signed [COORD_W:0] qs_q;

  // Restoring divider for the slope.
  logic [COORD_W-1:0]   div_a_q, div_r_q;
  logic [2:0]           div_cnt_q;

  logic [ADDR_W-1:0]    clr_cnt_q;
  logic                 oor_q;
  logic [BYTE_W-1:0]    rd_data_q;
  logic [BYTE_W-1:0]    frame_mem_q [DEPTH];
  logic [BYTE_W-1:0]    read_data_q;
  logic                 oor_out_q;

  // Line setup.
  logic                 x_lt, vert;
  logic [COORD_W:0]     dyn;
  logic [COORD_W-1:0]   dy_abs;
  logic [COORD_W-1:0]   y_min, y_max;

  always_comb begin
    x_lt   = sx_q < ex_q;
    vert   = (sx_q == ex_q) && (sy_q != ey_q);
    dyn    = x_lt ? ({1'b0, ey_q} - {1'b0, sy_q}) : ({1'b0, sy_q} - {1'b0, ey_q});
    dy_abs = dyn[COORD_W] ? COORD_W'(-dyn) : dyn[COORD_W-1:0];
    y_min  = (sy_q < ey_q) ? sy_q : ey_q;
    y_max  = (sy_q < ey_q) ? ey_q : sy_q;
  end

  // One quotient bit per step.
  logic [COORD_W:0]   trial, diff;
  logic               ge;

  always_comb begin
    trial = {div_r_q, div_a_q[COORD_W-1]};
    ge    = trial >= {1'b0, dxn_q};
    diff  = trial - {1'b0, dxn_q};
  end

  // Turn the truncated quotient of |dy|/dx into a floor quotient and remainder.
  logic [COORD_W:0]   a9;
  logic [COORD_W:0]   qs_fix;
  logic [COORD_W-1:0] rs_fix;

  always_comb begin
    a9 = {1'b0, div_a_q};
    if (!neg_q) begin
      qs_fix = a9;
      rs_fix = div_r_q;
    end else if (div_r_q == '0) begin
      qs_fix = -a9;
      rs_fix = '0;
    end else begin
      qs_fix = -a9 - 1'b1;
      rs_fix = dxn_q - div_r_q;
    end
  end

  // Incremental step: y grows by the floor quotient plus a carry from the remainder.
  logic [COORD_W:0]   acc_sum;
  logic               carry;
  logic [COORD_W+1:0] y_sum;

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, rs_q};
    carry   = acc_sum >= {1'b0, dxn_q};
    y_sum   = {2'b00, wy_q} + {qs_q[COORD_W], qs_q} + (COORD_W+2)'(carry);
  end

  // Pixel and byte addressing.
  logic               on_screen, rd_ok;
  logic [4:0]         pg;
  logic [BYTE_W-1:0]  mask;
  logic [ADDR_W-1:0]  pix_addr, byte_addr;

  always_comb begin
    on_screen = ({1'b0, wx_q} < 9'(SCREEN_COLUMNS)) && ({1'b0, wy_q} < 9'(ROWS));
    pg        = 5'(SCREEN_PAGES - 1) - wy_q[7:3];
    mask      = 8'h80 >> wy_q[2:0];
    pix_addr  = ADDR_W'(wx_q * SCREEN_PAGES + pg);
    rd_ok     = ({2'b00, rc_q} < 9'(SCREEN_COLUMNS)) && ({2'b00, rp_q} < 5'(SCREEN_PAGES));
    byte_addr = ADDR_W'(rc_q * SCREEN_PAGES + rp_q);
  end

  // Frame memory, one write and one registered read port.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata;

  always_comb begin
    mem_re    = cmd_i.pix_rd | cmd_i.byte_rd;
    mem_raddr = cmd_i.byte_rd ? byte_addr : pix_addr;
    mem_we    = cmd_i.clr_step | (cmd_i.pix_wr & on_screen);
    mem_waddr = cmd_i.clr_step ? clr_cnt_q : pix_addr;
    if (cmd_i.clr_step) begin
      mem_wdata = '0;
    end else if (on_q) begin
      mem_wdata = rd_data_q | mask;
    end else begin
      mem_wdata = rd_data_q & ~mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= frame_mem_q[mem_raddr];
    end
  end

  // Counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.line_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
      light_q <= light_i;
      rc_q    <= read_column_i;
      rp_q    <= read_page_i;
      oor_q   <= 1'b0;
    end
    if (cmd_i.pt_init) begin
      wx_q   <= sx_q;
      wy_q   <= sy_q;
      hi_q   <= sx_q;
      vert_q <= 1'b0;
      on_q   <= light_q;
    end
    if (cmd_i.line_init) begin
      wx_q    <= x_lt ? sx_q : ex_q;
      wy_q    <= vert ? y_min : (x_lt ? sy_q : ey_q);
      hi_q    <= vert ? y_max : (x_lt ? ex_q : sx_q);
      vert_q  <= vert;
      on_q    <= 1'b1;
      dxn_q   <= x_lt ? (ex_q - sx_q) : (sx_q - ex_q);
      neg_q   <= dyn[COORD_W];
      div_a_q <= dy_abs;
      div_r_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_r_q <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      div_a_q <= {div_a_q[COORD_W-2:0], ge};
    end
    if (cmd_i.div_fix) begin
      qs_q  <= $signed(qs_fix);
      rs_q  <= rs_fix;
      acc_q <= '0;
    end
    if (cmd_i.pix_wr) begin
      if (!on_screen) begin
        oor_q <= 1'b1;
      end
      if (vert_q) begin
        wy_q <= wy_q + 1'b1;
      end else begin
        wx_q  <= wx_q + 1'b1;
        wy_q  <= y_sum[COORD_W-1:0];
        acc_q <= carry ? COORD_W'(acc_sum - {1'b0, dxn_q}) : acc_sum[COORD_W-1:0];
      end
    end
    if (cmd_i.byte_rd && !rd_ok) begin
      oor_q <= 1'b1;
    end
    if (cmd_i.res_load) begin
      read_data_q <= (kind_q == KIND_READ && rd_ok) ? rd_data_q : '0;
      oor_out_q   <= oor_q;
    end
  end

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.div_last   = div_cnt_q == 3'd7;
    sts_o.walk_last  = vert_q ? (wy_q == hi_q) : (wx_q == hi_q);
    sts_o.sweep_last = clr_cnt_q == ADDR_W'(DEPTH - 1);
  end

  assign read_data_o    = read_data_q;
  assign out_of_range_o = oor_out_q;

endmodule

[rtl/mfpl_ctrl.sv]
// Controller: sequences sweeps, slope division and read-modify-write of pixels.
`include "assert_macros.svh"

module mfpl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  mfpl_pkg::sts_t sts_i,
  output mfpl_pkg::cmd_t cmd_o
);
  import mfpl_pkg::*;

  state_e st_q, st_d;
  logic   sweep_cmd_q, sweep_cmd_d;
  logic   m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_SWEEP;
      sweep_cmd_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      sweep_cmd_q <= sweep_cmd_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    sweep_cmd_d = sweep_cmd_q;
    m_valid_d   = m_valid_q;
    cmd_o       = '0;
    s_tready_o  = 1'b0;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_SWEEP: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) begin
          sweep_cmd_d = 1'b0;
          st_d        = sweep_cmd_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          st_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.kind)
          KIND_POINT: begin
            cmd_o.pt_init = 1'b1;
            st_d          = ST_PIX_RD;
          end
          KIND_LINE: begin
            cmd_o.line_init = 1'b1;
            st_d            = ST_DIV;
          end
          KIND_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            sweep_cmd_d     = 1'b1;
            st_d            = ST_SWEEP;
          end
          KIND_READ: begin
            st_d = ST_BYTE_RD;
          end
          default: begin
            st_d = ST_DONE;
          end
        endcase
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          st_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.div_fix = 1'b1;
        st_d          = ST_PIX_RD;
      end
      ST_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        st_d         = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        st_d         = sts_i.walk_last ? ST_DONE : ST_PIX_RD;
      end
      ST_BYTE_RD: begin
        cmd_o.byte_rd = 1'b1;
        st_d          = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied this cycle.
        if (!m_valid_q || m_tready_i) begin
          cmd_o.res_load = 1'b1;
          m_valid_d      = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_o = m_valid_q;

  `ASSERT_CLK(a_no_result_overwrite, clk_i, rst_ni, cmd_o.res_load |-> (!m_valid_q || m_tready_i), "result loaded over an untaken beat")
  `ASSERT_CLK(a_write_after_read, clk_i, rst_ni, cmd_o.pix_wr |-> $past(cmd_o.pix_rd), "pixel write without a preceding read")
  `ASSERT_CLK(a_fix_after_div, clk_i, rst_ni, (st_q == ST_FIX) |-> ($past(st_q) == ST_DIV && $past(sts_i.div_last)), "slope fixed before the division finished")
  `ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, s_tready_o && (cmd_o.pix_wr || cmd_o.clr_step || cmd_o.div_step), "input ready while a command is at work")

endmodule

[rtl/mono_framebuffer_point_line_draw.sv]
// One command is worked at a time: a point does one read-modify-write, a read fetches
// one byte, a clear sweeps the memory, and a line first runs a restoring slope divider
// and then walks each x (or y) position with a read-modify-write of its pixel over
// the memory's read and write ports.
// After reset the frame memory is zeroed by a sweep over SCREEN_COLUMNS*SCREEN_PAGES
// bytes (1024 at the defaults) while s_axis_tready stays low.
module mono_framebuffer_point_line_draw #(
  parameter int unsigned SCREEN_COLUMNS = mfpl_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_PAGES   = mfpl_pkg::SCREEN_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], light[32],
  //        read_column[39:33], read_page[42:40], zero fill[47:43]
  input  logic [mfpl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [mfpl_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: read_data[7:0]
  output logic [mfpl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // tuser: out_of_range[0]
  output logic [mfpl_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import mfpl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfpl_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_e'(s_axis_tuser[1:0])),
    .start_x_i      (s_axis_tdata[7:0]),
    .start_y_i      (s_axis_tdata[15:8]),
    .end_x_i        (s_axis_tdata[23:16]),
    .end_y_i        (s_axis_tdata[31:24]),
    .light_i        (s_axis_tdata[32]),
    .read_column_i  (s_axis_tdata[39:33]),
    .read_page_i    (s_axis_tdata[42:40]),
    .read_data_o    (m_axis_tdata),
    .out_of_range_o (m_axis_tuser[0])
  );

endmodule
